// ===== rtl/core/sclp_pkg.sv =====
// sclp_pkg: shared types, constants and name tables for the command line parser
// used by every module under rtl/core; depends on nothing

package sclp_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int NAME_SPACE = 10;
	localparam int NAME_COUNT = 6;
	localparam int NAME_CHARS = 4;

	localparam int CNT_W = $clog2(LINE_DEPTH + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	localparam logic [30:0] MAG_LIMIT = 31'h7FFF_FFFF;

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam int OUT_BYTES = (2 + 3 + 32 + 7) / 8;

	typedef enum logic [1:0] {
		ST_KNOWN    = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_LONG     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_SH   = 3'd1,
		CMD_ICG  = 3'd2,
		CMD_AVG  = 3'd3,
		CMD_DATA = 3'd4,
		CMD_RUN  = 3'd5,
		CMD_STOP = 3'd6
	} cmd_t;

	// classified character handed from front to back
	typedef struct packed {
		logic                                  is_end;
		logic                                  is_eq;
		logic                                  is_digit;
		logic [3:0]                            digit;
		logic                                  is_sign;
		logic                                  is_minus;
		logic                                  is_space;
		logic [NAME_CHARS-1:0][NAME_COUNT-1:0] hit;
	} token_t;

	function automatic logic [7:0] name_char(input int k, input int p);
		logic [31:0] txt;
		begin
			unique case (k)
				0: txt = {8'h00, 8'h3D, 8'h48, 8'h53};
				1: txt = {8'h3D, 8'h47, 8'h43, 8'h49};
				2: txt = {8'h3D, 8'h47, 8'h56, 8'h41};
				3: txt = {8'h41, 8'h54, 8'h41, 8'h44};
				4: txt = {8'h00, 8'h4E, 8'h55, 8'h52};
				default: txt = {8'h50, 8'h4F, 8'h54, 8'h53};
			endcase
			name_char = txt[p*8 +: 8];
		end
	endfunction

	function automatic logic [2:0] name_len(input int k);
		begin
			unique case (k)
				0, 4: name_len = 3'd3;
				default: name_len = 3'd4;
			endcase
		end
	endfunction

endpackage

// ===== rtl/core/sclp_front.sv =====
// sclp_front: input stage, drops blanks and classifies each character
// depends on sclp_pkg; feeds sclp_queue

module sclp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	output logic              push,
	output sclp_pkg::token_t  tok,
	input  logic              full
);

	logic             valid_s1;
	sclp_pkg::token_t tok_s1;
	sclp_pkg::token_t tok_d;
	logic             drop;
	logic             take;

	assign drop = (in_byte == sclp_pkg::CH_SPACE) || (in_byte == sclp_pkg::CH_CR) ||
		(in_byte == sclp_pkg::CH_LF);
	assign in_ready = !valid_s1 || !full;
	assign take = in_valid && in_ready;
	assign push = valid_s1 && !full;
	assign tok = tok_s1;

	always_comb begin
		tok_d = '0;
		tok_d.is_end = (in_byte == sclp_pkg::CH_SEMI);
		tok_d.is_eq = (in_byte == sclp_pkg::CH_EQ);
		tok_d.is_digit = (in_byte >= sclp_pkg::CH_ZERO) && (in_byte <= sclp_pkg::CH_NINE);
		tok_d.digit = 4'(in_byte - sclp_pkg::CH_ZERO);
		tok_d.is_sign = (in_byte == sclp_pkg::CH_PLUS) || (in_byte == sclp_pkg::CH_MINUS);
		tok_d.is_minus = (in_byte == sclp_pkg::CH_MINUS);
		tok_d.is_space = (in_byte == sclp_pkg::CH_TAB) || (in_byte == sclp_pkg::CH_VT) ||
			(in_byte == sclp_pkg::CH_FF);
		for (int p = 0; p < sclp_pkg::NAME_CHARS; p++) begin
			for (int k = 0; k < sclp_pkg::NAME_COUNT; k++) begin
				tok_d.hit[p][k] = (sclp_pkg::name_char(k, p) == in_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= !drop;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1 <= tok_d;
		end
	end

endmodule

// ===== rtl/core/sclp_queue.sv =====
// sclp_queue: short token queue between the classifier and the parser
// depends on sclp_pkg

module sclp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sclp_pkg::token_t  wr_tok,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output sclp_pkg::token_t  rd_tok
);

	sclp_pkg::token_t                 mem_q [sclp_pkg::FIFO_DEPTH];
	logic [sclp_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [sclp_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [sclp_pkg::FIFO_CW-1:0]     count_q;
	logic                             do_pop;

	assign full = (count_q == sclp_pkg::FIFO_CW'(sclp_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_tok = mem_q[rd_ptr_q];
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

endmodule

// ===== rtl/core/sclp_back.sv =====
// sclp_back: command state, name match, decimal conversion and result register
// depends on sclp_pkg; takes tokens from sclp_queue

module sclp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  sclp_pkg::token_t  tok,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output sclp_pkg::status_t res_status,
	output sclp_pkg::cmd_t    res_code,
	output logic [31:0]       res_value
);

	localparam logic [sclp_pkg::CNT_W-1:0] DEPTH_C = sclp_pkg::CNT_W'(sclp_pkg::LINE_DEPTH);
	localparam logic [sclp_pkg::CNT_W-1:0] NAME_LIM = sclp_pkg::CNT_W'(sclp_pkg::NAME_SPACE - 2);

	logic [sclp_pkg::CNT_W-1:0]      char_count_q;
	logic [sclp_pkg::NAME_COUNT-1:0] match_mask_q;
	logic                            equals_seen_q;
	logic                            name_overlong_q;
	logic                            param_started_q;
	logic [30:0]                     magnitude_q;
	logic                            negative_q;
	logic                            stopped_q;

	logic                            out_valid_q;
	sclp_pkg::status_t               status_q;
	sclp_pkg::cmd_t                  code_q;
	logic [31:0]                     value_q;

	logic                            overflow;
	logic [sclp_pkg::NAME_COUNT-1:0] keep;
	logic [34:0]                     ten_m;
	logic [30:0]                     mag_next;
	sclp_pkg::status_t               end_status;
	sclp_pkg::cmd_t                  end_code;
	logic [31:0]                     end_value;
	logic [sclp_pkg::NAME_COUNT-1:0] ok;

	assign pop = tok_valid && (!out_valid_q || res_ready);
	assign overflow = !tok.is_end && (char_count_q >= DEPTH_C);

	assign res_valid = out_valid_q;
	assign res_status = status_q;
	assign res_code = code_q;
	assign res_value = value_q;

	always_comb begin
		for (int k = 0; k < sclp_pkg::NAME_COUNT; k++) begin
			keep[k] = (char_count_q < sclp_pkg::CNT_W'(sclp_pkg::name_len(k))) &&
				tok.hit[char_count_q[1:0]][k];
		end
	end

	// times ten plus digit, saturated
	assign ten_m = ({4'b0, magnitude_q} << 3) + ({4'b0, magnitude_q} << 1) + 35'(tok.digit);
	assign mag_next = (ten_m > 35'(sclp_pkg::MAG_LIMIT)) ? sclp_pkg::MAG_LIMIT : ten_m[30:0];

	always_comb begin
		for (int k = 0; k < sclp_pkg::NAME_COUNT; k++) begin
			if (k < 3) begin
				ok[k] = match_mask_q[k] && equals_seen_q;
			end else begin
				ok[k] = match_mask_q[k] && !equals_seen_q &&
					(char_count_q == sclp_pkg::CNT_W'(sclp_pkg::name_len(k)));
			end
		end
		end_code = sclp_pkg::CMD_NONE;
		for (int k = sclp_pkg::NAME_COUNT - 1; k >= 0; k--) begin
			if (ok[k]) begin
				end_code = sclp_pkg::cmd_t'(3'(k + 1));
			end
		end
		end_value = '0;
		priority if (name_overlong_q) begin
			end_status = sclp_pkg::ST_LONG;
			end_code = sclp_pkg::CMD_NONE;
		end else if (end_code == sclp_pkg::CMD_NONE) begin
			end_status = sclp_pkg::ST_UNKNOWN;
		end else begin
			end_status = sclp_pkg::ST_KNOWN;
			if (end_code <= sclp_pkg::CMD_AVG) begin
				end_value = negative_q ? (32'd0 - {1'b0, magnitude_q}) : {1'b0, magnitude_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			match_mask_q <= '1;
			equals_seen_q <= 1'b0;
			name_overlong_q <= 1'b0;
			param_started_q <= 1'b0;
			magnitude_q <= '0;
			negative_q <= 1'b0;
			stopped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && (tok.is_end || overflow)) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (tok.is_end || overflow) begin
					char_count_q <= '0;
					match_mask_q <= '1;
					equals_seen_q <= 1'b0;
					name_overlong_q <= 1'b0;
					param_started_q <= 1'b0;
					magnitude_q <= '0;
					negative_q <= 1'b0;
					stopped_q <= 1'b0;
				end else begin
					char_count_q <= char_count_q + 1'b1;
					if (equals_seen_q) begin
						if (!stopped_q) begin
							priority if (tok.is_digit) begin
								magnitude_q <= mag_next;
								param_started_q <= 1'b1;
							end else if (!param_started_q && tok.is_sign) begin
								negative_q <= tok.is_minus;
								param_started_q <= 1'b1;
							end else if (!param_started_q && tok.is_space) begin
								// leading white space skipped
							end else begin
								stopped_q <= 1'b1;
							end
						end
					end else begin
						match_mask_q <= match_mask_q & keep;
						if (tok.is_eq) begin
							equals_seen_q <= 1'b1;
						end else if (char_count_q >= NAME_LIM) begin
							name_overlong_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (overflow) begin
				status_q <= sclp_pkg::ST_OVERFLOW;
				code_q <= sclp_pkg::CMD_NONE;
				value_q <= '0;
			end else if (tok.is_end) begin
				status_q <= end_status;
				code_q <= end_code;
				value_q <= end_value;
			end
		end
	end

endmodule

// ===== rtl/core/serial_command_line_parser_unit.sv =====
// serial_command_line_parser_unit: top level of the serial command line parser
// depends on sclp_pkg, sclp_front, sclp_queue and sclp_back
//
// channel  | dir | width | contents
// s_axis   | in  | 8     | tdata: data_byte[7:0]
// m_axis   | out | 40    | tdata: status[1:0], command_code[4:2], argument_value[36:5]
//
// one byte per cycle sustained while m_axis accepts; m_axis_tvalid rises once a ';'
// or overflowing byte has passed the classifier stage, queue and result register
// reset is asynchronous and needs no clearing pass
// when m_axis stalls the parser holds, the four-entry queue and the classifier
// stage fill, then s_axis_tready drops

module serial_command_line_parser_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // data_byte[7:0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// status[1:0], command_code[4:2], argument_value[36:5], zero[39:37]
	output logic [sclp_pkg::OUT_BYTES*8-1:0]   m_axis_tdata
);

	logic              push;
	logic              full;
	logic              pop;
	logic              not_empty;
	sclp_pkg::token_t  wr_tok;
	sclp_pkg::token_t  rd_tok;
	sclp_pkg::status_t status;
	sclp_pkg::cmd_t    code;
	logic [31:0]       value;

	sclp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.push     (push),
		.tok      (wr_tok),
		.full     (full)
	);

	sclp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_tok    (wr_tok),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_tok    (rd_tok)
	);

	sclp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (not_empty),
		.tok        (rd_tok),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_status (status),
		.res_code   (code),
		.res_value  (value)
	);

	assign m_axis_tdata = {3'b000, value, code, status};

endmodule
